@@ hdl/sitrd_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the signed integer to radix digits block
// no dependencies

package sitrd_pkg;

    localparam int IN_BITS    = 32;
    localparam int SYM_BITS   = 8;
    localparam int CFG_BITS   = 64;
    localparam int BASE_BITS  = 5;
    localparam int DIGIT_BITS = 4;
    localparam int CHUNK_BITS = 8;
    localparam int REG_IDX_BITS = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_BASE_LENGTH  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [BASE_BITS-1:0] BASE_LENGTH_RST  = 5'd10;
    localparam logic [CFG_BITS-1:0]  SYMBOLS_LOW_RST  = 64'h3736353433323130;
    localparam logic [CFG_BITS-1:0]  SYMBOLS_HIGH_RST = 64'h6665646362613938;

    localparam logic [SYM_BITS-1:0] SYM_SPACE = 8'h20;
    localparam logic [SYM_BITS-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_BITS-1:0] SYM_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [DIGIT_BITS-1:0] digit;
    } stack_ctrl_t;

endpackage

@@ hdl/sitrd_if.sv @@
`timescale 1ns / 1ps
// valid/ready channels for input numbers and output characters
// depends on sitrd_pkg

interface sitrd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sitrd_pkg::IN_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sitrd_out_if;
    logic                               valid;
    logic                               ready;
    logic [sitrd_pkg::SYM_BITS-1:0]     symbol;
    logic                               last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

@@ hdl/sitrd_digit_check.sv @@
`timescale 1ns / 1ps
// digit set check: radix range, repeated symbols, reserved symbols
// depends on sitrd_pkg

module sitrd_digit_check #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic [sitrd_pkg::BASE_BITS-1:0] base_length,
    input  logic [sitrd_pkg::CFG_BITS-1:0]  symbols_low,
    input  logic [sitrd_pkg::CFG_BITS-1:0]  symbols_high,
    output logic                            ok
);

    logic [2*sitrd_pkg::CFG_BITS-1:0] table_bits;
    logic                             bad;
    logic                             range_ok;

    assign table_bits = {symbols_high, symbols_low};
    assign range_ok   = (base_length >= sitrd_pkg::BASE_BITS'(2))
                     && (base_length <= sitrd_pkg::BASE_BITS'(MAX_SYMBOLS));

    always_comb
    begin
        bad = 1'b0;
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (sitrd_pkg::BASE_BITS'(i) < base_length)
            begin
                if (table_bits[i*8 +: 8] == sitrd_pkg::SYM_SPACE
                    || table_bits[i*8 +: 8] == sitrd_pkg::SYM_PLUS
                    || table_bits[i*8 +: 8] == sitrd_pkg::SYM_MINUS)
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (sitrd_pkg::BASE_BITS'(j) < base_length
                        && table_bits[i*8 +: 8] == table_bits[j*8 +: 8])
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign ok = range_ok && !bad;

endmodule

@@ hdl/sitrd_div_step.sv @@
`timescale 1ns / 1ps
// shared divide unit: one byte of the dividend against the radix per cycle
// depends on sitrd_pkg

module sitrd_div_step (
    input  logic [sitrd_pkg::DIGIT_BITS-1:0] rem_in,
    input  logic [sitrd_pkg::CHUNK_BITS-1:0] chunk,
    input  logic [sitrd_pkg::BASE_BITS-1:0]  radix,
    output logic [sitrd_pkg::DIGIT_BITS-1:0] rem_out,
    output logic [sitrd_pkg::CHUNK_BITS-1:0] quot
);

    logic [sitrd_pkg::DIGIT_BITS-1:0] r;
    logic [sitrd_pkg::BASE_BITS-1:0]  t;

    always_comb
    begin
        r    = rem_in;
        t    = '0;
        quot = '0;
        for (int i = sitrd_pkg::CHUNK_BITS - 1; i >= 0; i--)
        begin
            t = {r, chunk[i]};
            if (t >= radix)
            begin
                quot[i] = 1'b1;
                r       = sitrd_pkg::DIGIT_BITS'(t - radix);
            end
            else
            begin
                r = t[sitrd_pkg::DIGIT_BITS-1:0];
            end
        end
        rem_out = r;
    end

endmodule

@@ hdl/sitrd_digit_stack.sv @@
`timescale 1ns / 1ps
// lifo of digits, least significant pushed first, popped most significant first
// depends on sitrd_pkg

module sitrd_digit_stack #(
    parameter int DEPTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sitrd_pkg::stack_ctrl_t             ctrl,
    output logic [sitrd_pkg::DIGIT_BITS-1:0]   top,
    output logic [$clog2(DEPTH+1)-1:0]         count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [sitrd_pkg::DIGIT_BITS-1:0] stk_reg [DEPTH];
    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            stk_reg[0] <= ctrl.digit;
            for (int k = 1; k < DEPTH; k++)
            begin
                stk_reg[k] <= stk_reg[k-1];
            end
        end
        else if (ctrl.pop)
        begin
            for (int k = 0; k < DEPTH - 1; k++)
            begin
                stk_reg[k] <= stk_reg[k+1];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top   = stk_reg[0];
    assign count = count_reg;

endmodule

@@ hdl/signed_integer_to_radix_digits.sv @@
`timescale 1ns / 1ps
// top level: config registers, sequencer, output register
// depends on sitrd_pkg, sitrd_if, sitrd_digit_check, sitrd_div_step, sitrd_digit_stack
//
// usage
//   in_ch carries one signed number per beat; out_ch carries its text one
//   character per beat, most significant digit first, a leading minus for
//   negatives, last set on the final character. with an invalid digit set
//   the number is taken and nothing comes out.
//   cfg_write/cfg_index/cfg_data write base_length (0), symbols_low (1)
//   and symbols_high (2); other indexes are dropped. write only while idle.
// sequence
//   the number is captured, the digit set is checked, then each digit
//   is divided out in the shared divide unit (one byte of the dividend
//   per cycle), then the characters leave through the output register.
//   in_ch.ready is high only while the sequencer is idle; the next number
//   is taken while the final character still waits in the output register.
// reset
//   registers return to radix 10 and symbols "0123456789abcdef"; no beat
//   is pending. a stalled out_ch holds its beat and the sequencer waits.

module signed_integer_to_radix_digits #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    sitrd_in_if.sink                              in_ch,
    sitrd_out_if.source                           out_ch,
    input  logic                                  cfg_write,
    input  logic [sitrd_pkg::REG_IDX_BITS-1:0]    cfg_index,
    input  logic [sitrd_pkg::CFG_BITS-1:0]        cfg_data
);

    localparam int CHUNKS   = (VALUE_BITS + 7) / 8;
    localparam int PAD_BITS = CHUNKS * 8;
    localparam int CHUNK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CNT_W    = $clog2(VALUE_BITS + 1);

    sitrd_pkg::state_t state_reg, state_next;

    logic [sitrd_pkg::BASE_BITS-1:0]  base_length_reg;
    logic [sitrd_pkg::CFG_BITS-1:0]   symbols_low_reg;
    logic [sitrd_pkg::CFG_BITS-1:0]   symbols_high_reg;

    logic [PAD_BITS-1:0]              mag_reg, mag_next;
    logic                             neg_reg, neg_next;
    logic [sitrd_pkg::DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [CHUNK_W-1:0]               chunk_reg, chunk_next;
    logic                             nz_reg, nz_next;

    logic                             out_valid_reg, out_valid_next;
    logic [sitrd_pkg::SYM_BITS-1:0]   out_symbol_reg, out_symbol_next;
    logic                             out_last_reg, out_last_next;

    logic                             set_ok;
    logic [sitrd_pkg::DIGIT_BITS-1:0] step_rem;
    logic [sitrd_pkg::CHUNK_BITS-1:0] step_quot;
    logic                             last_chunk;
    logic                             quot_nz;
    logic                             slot_free;
    logic                             in_fire;
    logic [VALUE_BITS-1:0]            raw;
    logic [VALUE_BITS-1:0]            mag_abs;
    logic [2*sitrd_pkg::CFG_BITS-1:0] table_bits;
    logic [sitrd_pkg::DIGIT_BITS-1:0] stack_top;
    logic [CNT_W-1:0]                 stack_count;
    sitrd_pkg::stack_ctrl_t           stack_ctrl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg  <= sitrd_pkg::BASE_LENGTH_RST;
            symbols_low_reg  <= sitrd_pkg::SYMBOLS_LOW_RST;
            symbols_high_reg <= sitrd_pkg::SYMBOLS_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sitrd_pkg::REG_BASE_LENGTH:
                    base_length_reg <= cfg_data[sitrd_pkg::BASE_BITS-1:0];
                sitrd_pkg::REG_SYMBOLS_LOW:
                    symbols_low_reg <= cfg_data;
                sitrd_pkg::REG_SYMBOLS_HIGH:
                    symbols_high_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    sitrd_digit_check #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_check (
        .base_length  (base_length_reg),
        .symbols_low  (symbols_low_reg),
        .symbols_high (symbols_high_reg),
        .ok           (set_ok)
    );

    sitrd_div_step u_div (
        .rem_in  (rem_reg),
        .chunk   (mag_reg[PAD_BITS-1 -: sitrd_pkg::CHUNK_BITS]),
        .radix   (base_length_reg),
        .rem_out (step_rem),
        .quot    (step_quot)
    );

    sitrd_digit_stack #(
        .DEPTH (VALUE_BITS)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stack_ctrl),
        .top   (stack_top),
        .count (stack_count)
    );

    assign raw        = in_ch.value[VALUE_BITS-1:0];
    assign mag_abs    = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    assign last_chunk = (chunk_reg == CHUNK_W'(CHUNKS - 1));
    assign quot_nz    = nz_reg || (|step_quot);
    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign table_bits = {symbols_high_reg, symbols_low_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sitrd_pkg::ST_IDLE:
                if (in_ch.valid)
                begin
                    state_next = sitrd_pkg::ST_LOAD;
                end
            sitrd_pkg::ST_LOAD:
                state_next = set_ok ? sitrd_pkg::ST_DIV : sitrd_pkg::ST_IDLE;
            sitrd_pkg::ST_DIV:
                if (last_chunk && !quot_nz)
                begin
                    state_next = neg_reg ? sitrd_pkg::ST_SIGN : sitrd_pkg::ST_EMIT;
                end
            sitrd_pkg::ST_SIGN:
                if (slot_free)
                begin
                    state_next = sitrd_pkg::ST_EMIT;
                end
            sitrd_pkg::ST_EMIT:
                if (slot_free && stack_count == CNT_W'(1))
                begin
                    state_next = sitrd_pkg::ST_IDLE;
                end
            default:
                state_next = sitrd_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        in_ch.ready      = 1'b0;
        stack_ctrl       = '0;
        stack_ctrl.digit = step_rem;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        rem_next         = rem_reg;
        chunk_next       = chunk_reg;
        nz_next          = nz_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_symbol_next  = out_symbol_reg;
        out_last_next    = out_last_reg;
        unique case (state_reg)
            sitrd_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_fire)
                begin
                    mag_next = PAD_BITS'(mag_abs);
                    neg_next = raw[VALUE_BITS-1];
                end
            end
            sitrd_pkg::ST_LOAD:
            begin
                rem_next   = '0;
                chunk_next = '0;
                nz_next    = 1'b0;
            end
            sitrd_pkg::ST_DIV:
            begin
                mag_next   = (mag_reg << sitrd_pkg::CHUNK_BITS) | PAD_BITS'(step_quot);
                rem_next   = step_rem;
                chunk_next = chunk_reg + CHUNK_W'(1);
                nz_next    = quot_nz;
                if (last_chunk)
                begin
                    stack_ctrl.push = 1'b1;
                    rem_next        = '0;
                    chunk_next      = '0;
                    nz_next         = 1'b0;
                end
            end
            sitrd_pkg::ST_SIGN:
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_symbol_next = sitrd_pkg::SYM_MINUS;
                    out_last_next   = 1'b0;
                end
            sitrd_pkg::ST_EMIT:
                if (slot_free)
                begin
                    stack_ctrl.pop  = 1'b1;
                    out_valid_next  = 1'b1;
                    out_symbol_next = table_bits[{stack_top, 3'b000} +: sitrd_pkg::SYM_BITS];
                    out_last_next   = (stack_count == CNT_W'(1));
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sitrd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            chunk_reg     <= '0;
            nz_reg        <= 1'b0;
            rem_reg       <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chunk_reg     <= chunk_next;
            nz_reg        <= nz_next;
            rem_reg       <= rem_next;
            neg_reg       <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.symbol = out_symbol_reg;
    assign out_ch.last   = out_last_reg;

    // partial remainder stays below the radix while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sitrd_pkg::ST_DIV) |-> ({1'b0, rem_reg} < base_length_reg))
        else $error("remainder not below radix");

    // no digit pushed onto a full stack
    assert property (@(posedge clk) disable iff (!rst_n)
        stack_ctrl.push |-> (stack_count < CNT_W'(VALUE_BITS)))
        else $error("digit stack overflow");

    // characters only come from a non-empty stack
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sitrd_pkg::ST_EMIT || state_reg == sitrd_pkg::ST_SIGN)
        |-> (stack_count != '0))
        else $error("emitting with an empty digit stack");

    // a number is taken only with the stack drained
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (stack_count == '0))
        else $error("new number accepted with digits pending");

endmodule

@@ test/sitrd_text_checker.sv @@
`timescale 1ns / 1ps
// checker for the signed integer to radix digits block: tracks the register writes,
// predicts the characters of each accepted number and compares every output beat
// depends on sitrd_pkg and sitrd_if

module sitrd_text_checker #(
    parameter int MAX_SYMBOLS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    sitrd_in_if                                in_ch,
    sitrd_out_if                               out_ch,
    input  logic                               cfg_write,
    input  logic [sitrd_pkg::REG_IDX_BITS-1:0] cfg_index,
    input  logic [sitrd_pkg::CFG_BITS-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 chars_outstanding
);
    import sitrd_pkg::*;

    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic                last;
    } char_beat_t;

    char_beat_t           expected_text[$];
    logic [BASE_BITS-1:0] radix_reg = BASE_LENGTH_RST;
    logic [CFG_BITS-1:0]  low_reg   = SYMBOLS_LOW_RST;
    logic [CFG_BITS-1:0]  high_reg  = SYMBOLS_HIGH_RST;
    int                   fail_total = 0;

    function automatic logic [SYM_BITS-1:0] digit_symbol(int unsigned d);
        logic [2*CFG_BITS-1:0] glyphs;
        glyphs = {high_reg, low_reg};
        return glyphs[SYM_BITS*d +: SYM_BITS];
    endfunction

    function automatic bit digit_set_valid();
        int unsigned         n;
        logic [SYM_BITS-1:0] s;
        n = radix_reg;
        if (n < 2 || n > MAX_SYMBOLS)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            s = digit_symbol(i);
            if (s == SYM_SPACE || s == SYM_PLUS || s == SYM_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (digit_symbol(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(logic [IN_BITS-1:0] value);
        logic              neg;
        logic [IN_BITS-1:0] mag;
        int unsigned       digits[$];
        if (!digit_set_valid())
            return;
        neg = value[IN_BITS-1];
        // the most negative value wraps to itself, read unsigned it is 2^31
        mag = neg ? (~value + 1'b1) : value;
        do
        begin
            digits.push_front(int'(mag % radix_reg));
            mag = mag / radix_reg;
        end
        while (mag != 0);
        if (neg)
            expected_text.push_back('{symbol: SYM_MINUS, last: 1'b0});
        foreach (digits[k])
            expected_text.push_back('{symbol: digit_symbol(digits[k]),
                                      last: (k == digits.size() - 1)});
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_total++;
    endtask

    always @(posedge clk)
    begin
        char_beat_t want;
        if (!rst_n)
        begin
            radix_reg = BASE_LENGTH_RST;
            low_reg   = SYMBOLS_LOW_RST;
            high_reg  = SYMBOLS_HIGH_RST;
            expected_text.delete();
        end
        else
        begin
            if (cfg_write)
                case (cfg_index)
                    REG_BASE_LENGTH:  radix_reg = cfg_data[BASE_BITS-1:0];
                    REG_SYMBOLS_LOW:  low_reg   = cfg_data;
                    REG_SYMBOLS_HIGH: high_reg  = cfg_data;
                    default:          ;
                endcase
            if (in_ch.valid && in_ch.ready)
                predict_text(in_ch.value);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected character %h", out_ch.symbol));
                else
                begin
                    want = expected_text.pop_front();
                    if (out_ch.symbol !== want.symbol)
                        report_mismatch($sformatf("symbol %h, expected %h",
                                                  out_ch.symbol, want.symbol));
                    if (out_ch.last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  out_ch.last, want.last));
                end
            end
        end
        mismatches        = fail_total;
        chars_outstanding = expected_text.size();
    end

endmodule

@@ test/signed_integer_to_radix_digits_test.sv @@
`timescale 1ns / 1ps
// testbench top for signed_integer_to_radix_digits: register settings, number stimulus,
// output back-pressure and the verdict
// depends on sitrd_pkg, sitrd_if, sitrd_text_checker and the block itself

module signed_integer_to_radix_digits_test;
    import sitrd_pkg::*;

    localparam int CYCLE_LIMIT      = 1_200_000;
    localparam int DRAIN_CYCLES     = 300;
    localparam int RANDOM_ITEMS     = 190;
    localparam int HOLD_AFTER_BEATS = 600;
    localparam int HOLD_CYCLES      = 400;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef enum int {
        FLAW_SHORT,
        FLAW_WIDE,
        FLAW_REPEAT,
        FLAW_RESERVED
    } flaw_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_write;
    logic [REG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    int                      mismatches;
    int                      chars_outstanding;
    int                      cycle_count = 0;
    int                      out_beats = 0;
    int                      burst_left = 0;
    logic [SYM_BITS-1:0]     glyph [16];

    sitrd_in_if  in_ch ();
    sitrd_out_if out_ch ();

    always #1 clk = ~clk;

    signed_integer_to_radix_digits #(
        .MAX_SYMBOLS(16),
        .VALUE_BITS(32)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    sitrd_text_checker #(
        .MAX_SYMBOLS(16)
    ) text_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .chars_outstanding(chars_outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (out_ch.valid && out_ch.ready)
            out_beats <= out_beats + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: free runs, short and long stalls, one long hold while numbers keep coming
    initial
    begin
        int stall_left;
        int free_left;
        int r;
        bit held;
        stall_left = 0;
        free_left  = 0;
        held       = 1'b0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && out_beats >= HOLD_AFTER_BEATS && in_ch.valid)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
                free_left  = 0;
            end
            if (stall_left == 0 && free_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    free_left = $urandom_range(1, 40);
                else if (r < 90)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(10, 30);
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                free_left--;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [IN_BITS-1:0] pick_number(int unsigned base);
        int                 r;
        longint unsigned    p;
        logic [IN_BITS-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 30)
            v = $urandom;
        else if (r < 50)
            v = $urandom_range(0, 2000) - 1000;
        else if (r < 68)
        begin
            // around a power of the radix
            p = 1;
            repeat ($urandom_range(0, 31))
                if (p * base <= 64'h8000_0000)
                    p = p * base;
            v = p[IN_BITS-1:0] + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (r < 80)
            case ($urandom_range(0, 4))
                0:       v = 32'h0000_0000;
                1:       v = 32'h0000_0001;
                2:       v = 32'hFFFF_FFFF;
                3:       v = 32'h7FFF_FFFF;
                default: v = 32'h8000_0000;
            endcase
        else
        begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
                v = -v;
        end
        return v;
    endfunction

    task automatic send_number(input logic [IN_BITS-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic load_digits(input int unsigned base);
        logic [CFG_BITS-1:0] low_bits;
        logic [CFG_BITS-1:0] high_bits;
        for (int i = 0; i < 8; i++)
        begin
            low_bits[SYM_BITS*i +: SYM_BITS]  = glyph[i];
            high_bits[SYM_BITS*i +: SYM_BITS] = glyph[i + 8];
        end
        write_reg(REG_BASE_LENGTH, CFG_BITS'(base));
        write_reg(REG_SYMBOLS_LOW, low_bits);
        write_reg(REG_SYMBOLS_HIGH, high_bits);
    endtask

    task automatic end_writes();
        cfg_write <= 1'b0;
    endtask

    task automatic default_glyphs();
        for (int i = 0; i < 8; i++)
        begin
            glyph[i]     = SYMBOLS_LOW_RST[SYM_BITS*i +: SYM_BITS];
            glyph[i + 8] = SYMBOLS_HIGH_RST[SYM_BITS*i +: SYM_BITS];
        end
    endtask

    // wait for the text of every number, then for a number still in the divider
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (chars_outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_digits(output int unsigned base);
        int                  r;
        logic [SYM_BITS-1:0] s;
        bit                  clash;
        r = $urandom_range(0, 9);
        base = (r < 2) ? 2 : (r < 4) ? 16 : $urandom_range(2, 16);
        for (int i = 0; i < 16; i++)
        begin
            if (i < base)
            begin
                do
                begin
                    s = SYM_BITS'($urandom);
                    clash = (s == SYM_SPACE || s == SYM_PLUS || s == SYM_MINUS);
                    for (int j = 0; j < i; j++)
                        if (glyph[j] == s)
                            clash = 1'b1;
                end
                while (clash);
                glyph[i] = s;
            end
            else
                glyph[i] = SYM_BITS'($urandom);
        end
    endtask

    task automatic break_digits(inout int unsigned base);
        flaw_t flaw;
        int    i;
        flaw = flaw_t'($urandom_range(FLAW_SHORT, FLAW_RESERVED));
        case (flaw)
            FLAW_SHORT:  base = $urandom_range(0, 1);
            FLAW_WIDE:   base = $urandom_range(17, 31);
            FLAW_REPEAT:
            begin
                i = $urandom_range(1, base - 1);
                glyph[i] = glyph[$urandom_range(0, i - 1)];
            end
            default:
            begin
                i = $urandom_range(0, base - 1);
                case ($urandom_range(0, 2))
                    0:       glyph[i] = SYM_SPACE;
                    1:       glyph[i] = SYM_PLUS;
                    default: glyph[i] = SYM_MINUS;
                endcase
            end
        endcase
    endtask

    initial
    begin
        int unsigned base;
        int          n;
        int          counted;
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= REG_BASE_LENGTH;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // decimal after reset
        send_number(32'd0);
        send_number(32'd1);
        send_number(-32'sd1);
        send_number(32'd9);
        send_number(32'd10);
        send_number(32'd1_000_000_000);
        send_number(-32'sd1_000_000_000);
        send_number(32'h7FFF_FFFF);
        send_number(32'h8000_0000);
        settle();

        // radix 16 by the base register alone, bits above its width dropped
        write_reg(REG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
        end_writes();
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'd16);
        send_number(32'd255);
        settle();

        // binary with a zero byte as a digit, spare index ignored
        default_glyphs();
        glyph[0] = 8'h00;
        glyph[1] = 8'h7E;
        load_digits(2);
        write_reg(REG_SPARE, 64'h0000_0000_0000_0003);
        end_writes();
        send_number(32'h8000_0000);
        send_number(32'h7FFF_FFFF);
        send_number(32'd4);
        settle();

        // broken digit sets swallow the number
        default_glyphs();
        load_digits(0);
        end_writes();
        send_number(32'd5);
        settle();
        load_digits(1);
        end_writes();
        send_number(-32'sd5);
        settle();
        load_digits(17);
        end_writes();
        send_number(32'd123);
        settle();
        load_digits(31);
        end_writes();
        send_number(32'h8000_0000);
        settle();
        for (int i = 0; i < 16; i++)
            glyph[i] = (i < 8) ? 8'h00 : 8'hFF;
        load_digits(16);
        end_writes();
        send_number(32'd77);
        settle();
        default_glyphs();
        glyph[3] = SYM_SPACE;
        load_digits(10);
        end_writes();
        send_number(32'd3);
        settle();
        default_glyphs();
        glyph[9] = SYM_PLUS;
        load_digits(10);
        end_writes();
        send_number(32'd99);
        settle();
        default_glyphs();
        glyph[0] = SYM_MINUS;
        load_digits(10);
        end_writes();
        send_number(-32'sd100);
        settle();

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            random_digits(base);
            if ($urandom_range(0, 5) == 0)
            begin
                break_digits(base);
                load_digits(base);
                end_writes();
                repeat (3) send_number($urandom);
            end
            else
            begin
                load_digits(base);
                end_writes();
                n = $urandom_range(10, 30);
                repeat (n) send_number(pick_number(base));
                counted += n;
            end
            settle();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
